[design/kmp_pkg.sv]
// Shared types for the KMP stream matcher: operation codes and controller states.
package kmp_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

[design/kmp_if.sv]
// Valid/ready channel interfaces for the KMP matcher input and result items.
interface kmp_in_if #(
    parameter int SYMBOL_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             operation;
    logic [SYMBOL_BITS-1:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface kmp_out_if #(
    parameter int POSITION_BITS = 32,
    parameter int PREFIX_BITS   = 7
);
    logic                     valid;
    logic                     ready;
    logic                     match_found;
    logic [POSITION_BITS-1:0] end_position;
    logic [PREFIX_BITS-1:0]   prefix_length;
    logic                     pattern_full;

    modport source (output valid, output match_found, output end_position,
                    output prefix_length, output pattern_full, input ready);
    modport sink   (input valid, input match_found, input end_position,
                    input prefix_length, input pattern_full, output ready);
endinterface

[design/kmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/kmp_engine.sv]
// KMP controller: item decode, failure-table walk and pattern/matcher state.
module kmp_engine import kmp_pkg::*; #(
    parameter int MAX_PATTERN   = 64,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 32,
    localparam int IDX_W        = $clog2(MAX_PATTERN),
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input item
    input  logic                     i_valid,
    input  logic [1:0]               i_operation,
    input  logic [SYMBOL_BITS-1:0]   i_symbol,
    output logic                     o_ready,
    // pattern store
    output logic                     o_pat_we,
    output logic [IDX_W-1:0]         o_pat_waddr,
    output logic [SYMBOL_BITS-1:0]   o_pat_wdata,
    output logic [IDX_W-1:0]         o_pat_raddr,
    input  logic [SYMBOL_BITS-1:0]   i_pat_q,
    // failure table
    output logic                     o_fail_we,
    output logic [IDX_W-1:0]         o_fail_waddr,
    output logic [IDX_W-1:0]         o_fail_wdata,
    output logic [IDX_W-1:0]         o_fail_raddr,
    input  logic [IDX_W-1:0]         i_fail_q,
    // result
    input  logic                     i_out_free,
    output logic                     o_done,
    output logic                     o_found,
    output logic [POSITION_BITS-1:0] o_pos,
    output logic [LEN_W-1:0]         o_prefix,
    output logic                     o_full
);

    localparam logic [LEN_W-1:0] CAP = LEN_W'(MAX_PATTERN);

    t_state                   r_state, n_state;
    logic [LEN_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_bpl;
    logic [IDX_W-1:0]         r_match;
    logic [POSITION_BITS-1:0] r_pos;
    logic [IDX_W-1:0]         r_j;
    logic [SYMBOL_BITS-1:0]   r_sym;
    logic                     r_text;
    logic [POSITION_BITS-1:0] r_epos;
    logic                     r_res_found;
    logic [POSITION_BITS-1:0] r_res_pos;
    logic [LEN_W-1:0]         r_res_prefix;
    logic                     r_res_full;

    t_op              w_op;
    logic             w_accept;
    logic             w_go_scan;
    logic [IDX_W-1:0] w_raddr;
    logic [IDX_W-1:0] w_len0;
    logic [IDX_W-1:0] w_j0;
    logic             w_mism;
    logic             w_step;
    logic [LEN_W-1:0] w_len;

    assign w_op     = t_op'(i_operation);
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // starting lengths; out-of-range saved lengths restart at zero
    assign w_len0 = ({1'b0, r_bpl} >= r_count) ? '0 : r_bpl;
    assign w_j0   = ({1'b0, r_match} >= r_count) ? '0 : r_match;

    // one failure-table step per cycle while scanning
    assign w_mism = (i_pat_q != r_sym);
    assign w_step = (r_j != '0) && w_mism;
    assign w_len  = w_mism ? {1'b0, r_j} : ({1'b0, r_j} + LEN_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_go_scan) begin
                    n_state = ST_SCAN;
                end else if (o_done && !i_out_free) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (o_done) begin
                    n_state = i_out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls and result
    always_comb begin
        w_go_scan    = 1'b0;
        w_raddr      = r_j;
        o_pat_we     = 1'b0;
        o_pat_waddr  = r_count[IDX_W-1:0];
        o_pat_wdata  = i_symbol;
        o_fail_we    = 1'b0;
        o_fail_waddr = r_count[IDX_W-1:0];
        o_fail_wdata = '0;
        o_done       = 1'b0;
        o_found      = 1'b0;
        o_pos        = '0;
        o_prefix     = '0;
        o_full       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_CLEAR: begin
                            o_done = 1'b1;
                        end
                        OP_APPEND: begin
                            if (r_count == CAP) begin
                                o_done = 1'b1;
                                o_full = 1'b1;
                            end else begin
                                o_pat_we = 1'b1;
                                if (r_count == '0) begin
                                    // first symbol has an empty border
                                    o_fail_we = 1'b1;
                                    o_done    = 1'b1;
                                end else begin
                                    w_raddr   = w_len0;
                                    w_go_scan = 1'b1;
                                end
                            end
                        end
                        OP_TEXT: begin
                            if (r_count == '0) begin
                                o_done = 1'b1;
                                o_pos  = r_pos;
                            end else begin
                                w_raddr   = w_j0;
                                w_go_scan = 1'b1;
                            end
                        end
                        default: begin
                            o_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_step) begin
                    w_raddr = i_fail_q;
                end else begin
                    o_done   = 1'b1;
                    o_prefix = w_len;
                    if (r_text) begin
                        o_pos   = r_epos;
                        o_found = (w_len >= r_count);
                    end else begin
                        o_fail_we    = 1'b1;
                        o_fail_wdata = w_len[IDX_W-1:0];
                    end
                end
            end
            ST_FINISH: begin
                o_done   = 1'b1;
                o_found  = r_res_found;
                o_pos    = r_res_pos;
                o_prefix = r_res_prefix;
                o_full   = r_res_full;
            end
            default: ;
        endcase
    end

    assign o_pat_raddr  = w_raddr;
    assign o_fail_raddr = w_raddr - IDX_W'(1);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_bpl   <= '0;
            r_match <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_accept) begin
                case (w_op)
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_bpl   <= '0;
                        r_match <= '0;
                        r_pos   <= '0;
                    end
                    OP_APPEND: begin
                        if (r_count != CAP) begin
                            r_match <= '0;
                            r_pos   <= '0;
                            if (r_count == '0) begin
                                r_count <= LEN_W'(1);
                                r_bpl   <= '0;
                            end
                        end
                    end
                    OP_TEXT: begin
                        r_pos <= r_pos + POSITION_BITS'(1);
                    end
                    default: ;
                endcase
            end else if (r_state == ST_SCAN && !w_step) begin
                if (r_text) begin
                    // after a full match continue from the last border
                    r_match <= (w_len >= r_count) ? r_bpl : w_len[IDX_W-1:0];
                end else begin
                    r_bpl   <= w_len[IDX_W-1:0];
                    r_count <= r_count + LEN_W'(1);
                end
            end
        end
    end

    // working registers and parked result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_sym  <= i_symbol;
            r_text <= (w_op == OP_TEXT);
            r_epos <= r_pos;
        end
        if (r_state == ST_IDLE || w_step) begin
            r_j <= w_raddr;
        end
        if (o_done && !i_out_free) begin
            r_res_found  <= o_found;
            r_res_pos    <= o_pos;
            r_res_prefix <= o_prefix;
            r_res_full   <= o_full;
        end
    end

endmodule

[design/kmp_out_buf.sv]
// Result register that decouples the controller from the output channel.
module kmp_out_buf #(
    parameter int POSITION_BITS = 32,
    parameter int PREFIX_BITS   = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_done,
    input  logic                     i_found,
    input  logic [POSITION_BITS-1:0] i_pos,
    input  logic [PREFIX_BITS-1:0]   i_prefix,
    input  logic                     i_full,
    output logic                     o_free,
    kmp_out_if.source                o_out
);

    logic                     r_valid;
    logic                     r_found;
    logic [POSITION_BITS-1:0] r_pos;
    logic [PREFIX_BITS-1:0]   r_prefix;
    logic                     r_full;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_done) begin
            r_found  <= i_found;
            r_pos    <= i_pos;
            r_prefix <= i_prefix;
            r_full   <= i_full;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.match_found   = r_found;
    assign o_out.end_position  = r_pos;
    assign o_out.prefix_length = r_prefix;
    assign o_out.pattern_full  = r_full;

endmodule

[design/kmp_stream_matcher.sv]
// Clear, full append, first append and text on an empty pattern finish in the accept cycle.
// Other appends and text items finish in the scan state, after any failure-table fallbacks taken.
// Throughput: next item accepted the cycle after the previous result is registered.
// Each fallback is one read of the pattern RAM and the failure RAM in parallel.
// Reset: synchronous active low; clears pattern count, border, match length and position.
// Pattern and failure RAMs are not cleared; entries at or past the pattern count are never used.
module kmp_stream_matcher import kmp_pkg::*; #(
    parameter int MAX_PATTERN   = 64,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmp_in_if.sink    i_in,
    kmp_out_if.source o_out
);

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // pattern store ports
    logic                     w_pat_we;
    logic [IDX_W-1:0]         w_pat_waddr;
    logic [SYMBOL_BITS-1:0]   w_pat_wdata;
    logic [IDX_W-1:0]         w_pat_raddr;
    logic [SYMBOL_BITS-1:0]   w_pat_q;

    // failure table ports (entry k holds the border length of prefix k+1)
    logic                     w_fail_we;
    logic [IDX_W-1:0]         w_fail_waddr;
    logic [IDX_W-1:0]         w_fail_wdata;
    logic [IDX_W-1:0]         w_fail_raddr;
    logic [IDX_W-1:0]         w_fail_q;

    // result handoff
    logic                     w_out_free;
    logic                     w_done;
    logic                     w_found;
    logic [POSITION_BITS-1:0] w_pos;
    logic [LEN_W-1:0]         w_prefix;
    logic                     w_full;

    // Controller: decodes items, walks the failure table one step per cycle
    // (pattern[j] and failure[j-1] are read together), and keeps counters.
    kmp_engine #(
        .MAX_PATTERN   (MAX_PATTERN),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_operation  (i_in.operation),
        .i_symbol     (i_in.symbol),
        .o_ready      (i_in.ready),
        .o_pat_we     (w_pat_we),
        .o_pat_waddr  (w_pat_waddr),
        .o_pat_wdata  (w_pat_wdata),
        .o_pat_raddr  (w_pat_raddr),
        .i_pat_q      (w_pat_q),
        .o_fail_we    (w_fail_we),
        .o_fail_waddr (w_fail_waddr),
        .o_fail_wdata (w_fail_wdata),
        .o_fail_raddr (w_fail_raddr),
        .i_fail_q     (w_fail_q),
        .i_out_free   (w_out_free),
        .o_done       (w_done),
        .o_found      (w_found),
        .o_pos        (w_pos),
        .o_prefix     (w_prefix),
        .o_full       (w_full)
    );

    kmp_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_waddr (w_pat_waddr),
        .i_wdata (w_pat_wdata),
        .i_raddr (w_pat_raddr),
        .o_rdata (w_pat_q)
    );

    kmp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_fail_we),
        .i_waddr (w_fail_waddr),
        .i_wdata (w_fail_wdata),
        .i_raddr (w_fail_raddr),
        .o_rdata (w_fail_q)
    );

    // Output register: a finished item parks here while the sink stalls,
    // so the controller can already take the next item.
    kmp_out_buf #(
        .POSITION_BITS (POSITION_BITS),
        .PREFIX_BITS   (LEN_W)
    ) u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_done   (w_done),
        .i_found  (w_found),
        .i_pos    (w_pos),
        .i_prefix (w_prefix),
        .i_full   (w_full),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule
